FILE: src/aes128_encrypt_block_unit_defines.svh
// ----------------------------------------------------------------------------
// AES-128 encryption unit: assertion macros
// Shared macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef AES128_ENCRYPT_BLOCK_UNIT_DEFINES_SVH
`define AES128_ENCRYPT_BLOCK_UNIT_DEFINES_SVH

// antecedent implies consequent, checked on every rising edge out of reset
`define AES128ENC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never be seen out of reset
`define AES128ENC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: src/aes128enc_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 encryption package
// Types, round constants, S-box and column mixing shared by the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aes128enc_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [63:0]  half_t;
  typedef logic [31:0]  word_t;
  typedef logic [7:0]   byte_t;

  localparam int unsigned NUM_ROUNDS = 10;
  localparam int unsigned LATENCY    = NUM_ROUNDS + 1;

  localparam byte_t RCON [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
  };

  localparam byte_t SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic byte_t sbox(input byte_t b);
    return SBOX[b];
  endfunction

  // multiply by 2 in GF(2^8)
  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  // one MixColumns column, first byte in the top bits
  function automatic word_t mix_col(input word_t col);
    byte_t a0, a1, a2, a3;
    a0 = col[31:24];
    a1 = col[23:16];
    a2 = col[15:8];
    a3 = col[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

endpackage

`default_nettype wire

FILE: src/aes128_encrypt_block_unit.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption unit
// Fully unrolled, pipelined AES-128 encryption with on-the-fly key schedule.
// ----------------------------------------------------------------------------
// Usage notes:
//  - Request channel: drive key and plaintext halves on in_* and raise start.
//    A request is taken at every rising edge with start high and busy low.
//  - busy is only high while rst_n is low; out of reset the unit takes one
//    request every cycle, back to back, with no gaps.
//  - Result channel: out_valid marks ciphertext on out_cipher_hi/lo for
//    exactly one cycle. The receiver has no back-pressure and must take it.
//  - Pipeline: one whitening stage, then ten round stages (one per AES
//    round), each a register holding state and round key.
//  - Throughput: one block per cycle; set by the single round per stage.
//  - Results leave in request order, one per request.
//  - Reset (synchronous, active low) clears the valid bits of every stage;
//    requests in flight are dropped and no stray result appears.
//  - Byte order follows FIPS-197: byte 0 sits in bits 63..56 of the high
//    half, byte 8 in bits 63..56 of the low half.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_encrypt_block_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  aes128enc_pkg::half_t in_key_hi,
  input  aes128enc_pkg::half_t in_key_lo,
  input  aes128enc_pkg::half_t in_block_hi,
  input  aes128enc_pkg::half_t in_block_lo,
  output logic                 out_valid,
  output aes128enc_pkg::half_t out_cipher_hi,
  output aes128enc_pkg::half_t out_cipher_lo
);
  import aes128enc_pkg::*;

  // stage 0 registers: whitened state and the cipher key
  logic vld0_r, vld0_nxt;
  blk_t state0_r, state0_nxt;
  blk_t key0_r, key0_nxt;

  // per-stage buses; index i feeds round i, index NUM_ROUNDS is the result
  logic vld_w   [NUM_ROUNDS + 1];
  blk_t state_w [NUM_ROUNDS + 1];
  blk_t key_w   [NUM_ROUNDS + 1];

  // never stalls; only held off while in reset
  assign busy = ~rst_n;

  always_comb begin
    vld0_nxt   = start & ~busy;
    key0_nxt   = {in_key_hi, in_key_lo};
    state0_nxt = {in_block_hi, in_block_lo} ^ key0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= vld0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    state0_r <= state0_nxt;
    key0_r   <= key0_nxt;
  end

  assign vld_w[0]   = vld0_r;
  assign state_w[0] = state0_r;
  assign key_w[0]   = key0_r;

  // ten round stages; the last one skips MixColumns
  for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
    aes128enc_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_i   (vld_w[i]),
      .state_i (state_w[i]),
      .key_i   (key_w[i]),
      .rcon_i  (RCON[i]),
      .last_i  (1'(i == NUM_ROUNDS - 1)),
      .vld_o   (vld_w[i+1]),
      .state_o (state_w[i+1]),
      .key_o   (key_w[i+1])
    );
  end

  assign out_valid     = vld_w[NUM_ROUNDS];
  assign out_cipher_hi = state_w[NUM_ROUNDS][127:64];
  assign out_cipher_lo = state_w[NUM_ROUNDS][63:0];

endmodule

`default_nettype wire

FILE: src/aes128enc_round.sv
// ----------------------------------------------------------------------------
// AES-128 round stage
// One cipher round and the matching key expansion step, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128enc_round (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  vld_i,
  input  aes128enc_pkg::blk_t  state_i,
  input  aes128enc_pkg::blk_t  key_i,
  input  aes128enc_pkg::byte_t rcon_i,
  input  wire                  last_i,
  output logic                 vld_o,
  output aes128enc_pkg::blk_t  state_o,
  output aes128enc_pkg::blk_t  key_o
);
  import aes128enc_pkg::*;

  logic  vld_r;
  blk_t  state_r, state_nxt;
  blk_t  key_r, key_nxt;
  blk_t  shifted, mixed;
  word_t kt;

  always_comb begin
    // SubBytes + ShiftRows: out byte (c,r) takes in byte ((c+r)&3, r)
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 8*(c*4 + r) -: 8] =
          sbox(state_i[127 - 8*((((c + r) & 3) * 4) + r) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      mixed[127 - 32*c -: 32] = mix_col(shifted[127 - 32*c -: 32]);
    end

    // key schedule: RotWord, SubWord, rcon, then word chain
    kt = {sbox(key_i[23:16]) ^ rcon_i, sbox(key_i[15:8]),
          sbox(key_i[7:0]), sbox(key_i[31:24])};
    key_nxt[127:96] = key_i[127:96] ^ kt;
    key_nxt[95:64]  = key_i[95:64]  ^ key_nxt[127:96];
    key_nxt[63:32]  = key_i[63:32]  ^ key_nxt[95:64];
    key_nxt[31:0]   = key_i[31:0]   ^ key_nxt[63:32];

    state_nxt = (last_i ? shifted : mixed) ^ key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
    key_r   <= key_nxt;
  end

  assign vld_o   = vld_r;
  assign state_o = state_r;
  assign key_o   = key_r;

endmodule

`default_nettype wire

FILE: src/aes128enc_chk.sv
// ----------------------------------------------------------------------------
// AES-128 encryption unit: port checker
// Latency, ordering and determinism checks seen from the ports, bound in.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aes128_encrypt_block_unit_defines.svh"

module aes128enc_chk (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input aes128enc_pkg::half_t in_key_hi,
  input aes128enc_pkg::half_t in_key_lo,
  input aes128enc_pkg::half_t in_block_hi,
  input aes128enc_pkg::half_t in_block_lo,
  input wire                  out_valid,
  input aes128enc_pkg::half_t out_cipher_hi,
  input aes128enc_pkg::half_t out_cipher_lo
);
  import aes128enc_pkg::*;

  // gated on the sampled reset so the edge that releases reset is not flagged
  `AES128ENC_ASSERT_IMP(a_no_busy, rst_n, !busy, "busy raised out of reset")

  `AES128ENC_ASSERT_IMP(a_req_to_res, start && !busy, ##11 out_valid, "result missing")

  `AES128ENC_ASSERT_IMP(a_res_from_req, out_valid, $past(start && !busy, 11), "stray result")

  // identical back-to-back requests give identical back-to-back results
  `AES128ENC_ASSERT_IMP(a_same_req,
    start && !busy && $past(start && !busy) &&
    $stable(in_key_hi) && $stable(in_key_lo) &&
    $stable(in_block_hi) && $stable(in_block_lo),
    ##11 (out_valid && $stable(out_cipher_hi) && $stable(out_cipher_lo)),
    "result not repeatable")

endmodule

bind aes128_encrypt_block_unit aes128enc_chk u_aes128enc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_key_hi     (in_key_hi),
  .in_key_lo     (in_key_lo),
  .in_block_hi   (in_block_hi),
  .in_block_lo   (in_block_lo),
  .out_valid     (out_valid),
  .out_cipher_hi (out_cipher_hi),
  .out_cipher_lo (out_cipher_lo)
);

`default_nettype wire
